/* rtl/pnpt_pkg.sv */
// Shared constants, codes and types of the path nearest point tracker.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
package pnpt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int LEN_W      = 11;
    localparam int RANGE_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE    = 1'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

endpackage

/* rtl/pnpt_isqrt.sv */
// Iterative floored integer square root, one result bit per cycle.
// Depends on pnpt_pkg.
`timescale 1ns / 1ps
module pnpt_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pnpt_pkg::SQ_W-1:0] i_value,
    output pnpt_pkg::t_root_rsp       o_rsp
);
    import pnpt_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 1;

    logic [SQ_W-1:0]   r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    logic              w_ge;

    // Bring down two bits and try the next root bit.
    assign w_rem_sh = {r_rem, r_val[SQ_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[SQ_W-3:0], 2'b00};
                r_rem  <= w_ge ? REM_W'(w_rem_sh - w_trial) : REM_W'(w_rem_sh);
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("square root restarted while busy");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done raised while still iterating");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held for more than one cycle");

endmodule

/* rtl/path_nearest_point_tracker.sv */
// Top level of the windowed nearest point tracker: path memory, query sequencer.
// Depends on pnpt_pkg and pnpt_isqrt.
//
// Use: the slave stream carries items. tuser = 0 is a load transfer that writes one
// path point at point_index and gives no result; tuser = 1 is a query transfer that
// gives a position. Each query gives one master transfer with the nearest path
// index inside the search window and the floored distance to it, and that index
// becomes the centre of the next window. The configuration port sets the path
// length and the search range; the user writes it only while the block is idle,
// which the block itself does not enforce.
// Throughput: one item at a time. A query passes through its input transfer, the
// end check, the segments of each walk, each searched point, the final root and
// the result transfer. Every square root goes through the single serial square
// root unit, and the one read port of the path memory feeds one point a cycle.
// Reset clears the last found index to zero and the registers to their defaults;
// the path memory holds no reset value and must be loaded before use.
// A stalled receiver holds the result in the output register; no new item is
// taken until the result transfer completes.
`timescale 1ns / 1ps
module path_nearest_point_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: point_index [9:0], pos_x [33:10], pos_y [57:34], pos_z [81:58], zeros
    input  logic [87:0]                       s_axis_tdata,
    // tuser: operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: nearest_index [9:0], nearest_distance [34:10], zeros
    output logic [39:0]                       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [pnpt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pnpt_pkg::RANGE_W-1:0]      i_cfg_data
);
    import pnpt_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_LA   = 10'b0000000010,
        ST_LA2  = 10'b0000000100,
        ST_RD   = 10'b0000001000,
        ST_DIF  = 10'b0000010000,
        ST_SQ   = 10'b0000100000,
        ST_SUM  = 10'b0001000000,
        ST_USE  = 10'b0010000000,
        ST_ROOT = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } t_state;

    // Which part of the query the shared datapath is serving.
    typedef enum logic [4:0] {
        PH_D    = 5'b00001,
        PH_FWD  = 5'b00010,
        PH_BWD  = 5'b00100,
        PH_SRCH = 5'b01000,
        PH_FIN  = 5'b10000
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    // Path memory: one word per point, with a registered read.
    t_point mem [MAX_POINTS];
    t_point r_rdata;

    logic [LEN_W-1:0]   r_plen;
    logic [RANGE_W-1:0] r_rng;
    logic [IDX_W-1:0]   r_last;
    logic [IDX_W-1:0]   r_lastidx;
    logic [IDX_W-1:0]   r_prev;
    logic [IDX_W-1:0]   r_addr;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_start;
    logic [IDX_W-1:0]   r_end;
    logic [IDX_W-1:0]   r_best;
    logic [SQ_W-1:0]    r_bsq;
    logic [SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [ROOT_W-1:0]  r_dist;
    t_point             r_pos;
    t_point             r_a;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-2:0]    r_qx, r_qy, r_qz;

    t_point             w_in_pt;
    logic [IDX_W-1:0]   w_in_idx;
    logic [IDX_W-1:0]   w_nm1;
    logic [IDX_W-1:0]   w_prev;
    logic               w_upd;
    logic               w_more;
    logic               w_sq_start;
    logic [SQ_W-1:0]    w_sq_val;
    t_root_rsp          w_sq;
    logic [SUM_W-1:0]   w_nsum;
    logic signed [SQ_W-1:0] w_px, w_py, w_pz;

    assign w_in_idx   = s_axis_tdata[9:0];
    assign w_in_pt.x  = s_axis_tdata[33:10];
    assign w_in_pt.y  = s_axis_tdata[57:34];
    assign w_in_pt.z  = s_axis_tdata[81:58];

    // Effective last point index, path length clamped to the memory.
    always_comb begin
        if (r_plen < LEN_W'(2)) begin
            w_nm1 = IDX_W'(1);
        end else if (r_plen > LEN_W'(MAX_POINTS)) begin
            w_nm1 = IDX_W'(MAX_POINTS - 1);
        end else begin
            w_nm1 = IDX_W'(r_plen - 1'b1);
        end
    end
    assign w_prev = (r_last > w_nm1) ? w_nm1 : r_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {5'b0, r_dist, r_best};

    // Search step: keep the first strictly smaller squared distance.
    assign w_upd  = (r_i == r_start) || (r_sq < r_bsq);
    assign w_more = ({1'b0, r_i} + 1'b1) < {1'b0, r_end};
    assign w_sq_start = (r_state == ST_USE) && ((r_phase != PH_SRCH) || !w_more);
    assign w_sq_val   = (r_phase == PH_SRCH && !w_upd) ? r_bsq : r_sq;
    assign w_nsum     = r_sum + SUM_W'(w_sq.root);

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    pnpt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_sq_val),
        .o_rsp   (w_sq)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid && s_axis_tuser == OP_LOAD) begin
            mem[w_in_idx] <= w_in_pt;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_D;
            r_last  <= '0;
            r_plen  <= LEN_W'(2);
            r_rng   <= RANGE_W'(2000);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PATH_LEN: r_plen <= i_cfg_data[LEN_W-1:0];
                    CFG_RANGE:    r_rng  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tuser == OP_QUERY) begin
                        r_pos     <= w_in_pt;
                        r_lastidx <= w_nm1;
                        r_prev    <= w_prev;
                        r_addr    <= w_prev;
                        r_phase   <= PH_D;
                        r_state   <= ST_LA;
                    end
                end
                ST_LA: r_state <= ST_LA2;
                ST_LA2: begin
                    r_a <= r_rdata;
                    unique case (r_phase)
                        PH_FWD:  r_addr <= r_i + 1'b1;
                        PH_BWD:  r_addr <= r_i - 1'b1;
                        default: r_addr <= r_lastidx;
                    endcase
                    r_state <= ST_RD;
                end
                ST_RD: r_state <= ST_DIF;
                ST_DIF: begin
                    r_dx <= DIFF_W'(r_a.x) - DIFF_W'(r_rdata.x);
                    r_dy <= DIFF_W'(r_a.y) - DIFF_W'(r_rdata.y);
                    r_dz <= DIFF_W'(r_a.z) - DIFF_W'(r_rdata.z);
                    // Walking: the far end of this segment starts the next one.
                    if (r_phase != PH_SRCH) begin
                        r_a <= r_rdata;
                    end
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_qx    <= w_px[SQ_W-2:0];
                    r_qy    <= w_py[SQ_W-2:0];
                    r_qz    <= w_pz[SQ_W-2:0];
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_sq    <= SQ_W'(r_qx) + SQ_W'(r_qy) + SQ_W'(r_qz);
                    r_state <= ST_USE;
                end
                ST_USE: begin
                    if (r_phase == PH_SRCH) begin
                        if (w_upd) begin
                            r_best <= r_i;
                            r_bsq  <= r_sq;
                        end
                        if (w_more) begin
                            r_i     <= r_i + 1'b1;
                            r_addr  <= r_i + 1'b1;
                            r_state <= ST_RD;
                        end else begin
                            r_phase <= PH_FIN;
                            r_state <= ST_ROOT;
                        end
                    end else begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (w_sq.done) begin
                        unique case (r_phase)
                            PH_D: begin
                                if (ROOT_W'(r_rng) >= w_sq.root) begin
                                    // Range reaches the straight distance to the last point: window runs to the end.
                                    r_end   <= r_lastidx;
                                    r_start <= r_prev;
                                    r_i     <= r_prev;
                                    r_sum   <= '0;
                                    if (r_prev != '0) begin
                                        r_addr  <= r_prev;
                                        r_phase <= PH_BWD;
                                        r_state <= ST_LA;
                                    end else begin
                                        r_a     <= r_pos;
                                        r_addr  <= r_prev;
                                        r_phase <= PH_SRCH;
                                        r_state <= ST_RD;
                                    end
                                end else begin
                                    r_end   <= r_prev;
                                    r_i     <= r_prev;
                                    r_sum   <= '0;
                                    r_addr  <= r_prev;
                                    r_phase <= PH_FWD;
                                    r_state <= ST_LA;
                                end
                            end
                            PH_FWD: begin
                                if (w_nsum < SUM_W'(r_rng)
                                        && ({1'b0, r_i} + 1'b1) < {1'b0, r_lastidx}) begin
                                    r_end   <= r_i;
                                    r_sum   <= w_nsum;
                                    r_i     <= r_i + 1'b1;
                                    r_addr  <= IDX_W'(r_i + 2'd2);
                                    r_state <= ST_RD;
                                end else begin
                                    if (w_nsum < SUM_W'(r_rng)) begin
                                        r_end <= r_i;
                                    end
                                    r_start <= r_prev;
                                    r_i     <= r_prev;
                                    r_sum   <= '0;
                                    if (r_prev != '0) begin
                                        r_addr  <= r_prev;
                                        r_phase <= PH_BWD;
                                        r_state <= ST_LA;
                                    end else begin
                                        r_a     <= r_pos;
                                        r_addr  <= r_prev;
                                        r_phase <= PH_SRCH;
                                        r_state <= ST_RD;
                                    end
                                end
                            end
                            PH_BWD: begin
                                if ({w_nsum, 1'b0} < (SUM_W + 1)'(r_rng)) begin
                                    r_start <= r_i;
                                    r_sum   <= w_nsum;
                                    if (r_i > IDX_W'(1)) begin
                                        r_i     <= r_i - 1'b1;
                                        r_addr  <= IDX_W'(r_i - 2'd2);
                                        r_state <= ST_RD;
                                    end else begin
                                        r_a     <= r_pos;
                                        r_addr  <= r_i;
                                        r_phase <= PH_SRCH;
                                        r_state <= ST_RD;
                                    end
                                end else begin
                                    r_a     <= r_pos;
                                    r_i     <= r_start;
                                    r_addr  <= r_start;
                                    r_phase <= PH_SRCH;
                                    r_state <= ST_RD;
                                end
                            end
                            PH_FIN: begin
                                r_dist  <= w_sq.root;
                                r_last  <= r_best;
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output open at once");
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_USE && r_phase == PH_SRCH)
            |-> (r_i >= r_start && (r_i == r_start || r_i < r_end)))
        else $error("search index left the window");
    a_prev_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_prev <= r_lastidx))
        else $error("previous index beyond the last point");
    a_result_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_best <= r_lastidx && r_last == r_best))
        else $error("result index not kept or beyond the path");

endmodule

/* sim/pnpt_checker.sv */
// Scoreboard for the path nearest point tracker: keeps its own path copy and window logic.
// Depends on pnpt_pkg; instantiated beside the block by tb_path_nearest_point_tracker.
`timescale 1ns / 1ps
module pnpt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [87:0]                    s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [39:0]                    m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [pnpt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pnpt_pkg::RANGE_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import pnpt_pkg::*;

    typedef struct packed {
        logic [9:0]  index;
        logic [24:0] distance;
    } t_nearest;

    int              pt_x [MAX_POINTS];
    int              pt_y [MAX_POINTS];
    int              pt_z [MAX_POINTS];
    int unsigned     last_idx;
    int unsigned     plen_reg;
    int unsigned     range_reg;
    t_nearest        expected_q [$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned dist_sq(int ax, int ay, int az, int unsigned j);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(ax) - pt_x[j];
        dy = longint'(ay) - pt_y[j];
        dz = longint'(az) - pt_z[j];
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic longint unsigned seg_len(int unsigned a, int unsigned b);
        return root_floor(dist_sq(pt_x[a], pt_y[a], pt_z[a], b));
    endfunction

    // Window search around the last found index; updates that index.
    function automatic t_nearest find_nearest(int qx, int qy, int qz);
        int unsigned     n;
        int unsigned     prev;
        int unsigned     w_start;
        int unsigned     w_end;
        int unsigned     best;
        longint unsigned acc;
        longint unsigned best_sq;
        longint unsigned d;
        t_nearest        res;
        n = plen_reg;
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        prev = last_idx;
        if (prev >= n) prev = n - 1;
        // The forward side is the whole remaining path when the range reaches the
        // straight distance to the final point; otherwise walk segment lengths.
        if (longint'(range_reg) >= seg_len(prev, n - 1)) begin
            w_end = n - 1;
        end else begin
            w_end = prev;
            acc = 0;
            for (int unsigned i = prev; i + 1 < n; i++) begin
                acc += seg_len(i, i + 1);
                if (acc < range_reg) w_end = i;
                else break;
            end
        end
        // The backward side uses half the range, compared exactly as twice the sum.
        w_start = prev;
        acc = 0;
        for (int i = int'(prev); i >= 1; i--) begin
            acc += seg_len(i, i - 1);
            if (2 * acc < range_reg) w_start = i;
            else break;
        end
        best = w_start;
        best_sq = dist_sq(qx, qy, qz, w_start);
        for (int unsigned i = w_start + 1; i < w_end; i++) begin
            d = dist_sq(qx, qy, qz, i);
            if (d < best_sq) begin
                best_sq = d;
                best = i;
            end
        end
        last_idx = best;
        res.index = best[9:0];
        res.distance = 25'(root_floor(best_sq));
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_nearest got;
        t_nearest want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_POINTS; i++) begin
                pt_x[i] = 0;
                pt_y[i] = 0;
                pt_z[i] = 0;
            end
            last_idx = 0;
            plen_reg = 2;
            range_reg = 2000;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.index = m_axis_tdata[9:0];
                got.distance = m_axis_tdata[34:10];
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with nothing expected: index %0d distance %0d",
                                 $realtime, got.index, got.distance);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.index !== want.index || got.distance !== want.distance) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch: expected index %0d distance %0d, got %0d %0d",
                                     $realtime, want.index, want.distance,
                                     got.index, got.distance);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_LOAD) begin
                    pt_x[s_axis_tdata[9:0]] = int'($signed(s_axis_tdata[33:10]));
                    pt_y[s_axis_tdata[9:0]] = int'($signed(s_axis_tdata[57:34]));
                    pt_z[s_axis_tdata[9:0]] = int'($signed(s_axis_tdata[81:58]));
                end else begin
                    expected_q.insert(expected_q.size(),
                                      find_nearest(int'($signed(s_axis_tdata[33:10])),
                                                   int'($signed(s_axis_tdata[57:34])),
                                                   int'($signed(s_axis_tdata[81:58]))));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PATH_LEN) plen_reg = i_cfg_data[10:0];
                else if (i_cfg_idx == CFG_RANGE) range_reg = i_cfg_data;
            end
        end
    end

endmodule

/* sim/tb_path_nearest_point_tracker.sv */
// Top of the testbench for the path nearest point tracker: clock, reset, stimulus, verdict.
// Depends on pnpt_pkg, path_nearest_point_tracker and the pnpt_checker scoreboard.
`timescale 1ns / 1ps
module tb_path_nearest_point_tracker;
    import pnpt_pkg::*;

    // Cycles without any transfer before the run is declared hung. The slowest
    // query walks every segment of a full path and then searches its window.
    localparam int HANG_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [87:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [RANGE_W-1:0]   i_cfg_data;
    int                   fail_count;
    int                   pending;

    // The stimulus keeps its own picture of the path so that queries land near it
    // and no query ever reaches a point that has not been loaded.
    int                   path_x [MAX_POINTS];
    int                   path_y [MAX_POINTS];
    int                   path_z [MAX_POINTS];
    bit                   loaded [MAX_POINTS];
    bit                   no_gaps;
    int                   n_loads;
    int                   n_queries;
    int                   n_settings;
    int                   idle_cycles;

    path_nearest_point_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    pnpt_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The receiver stalls about a quarter of the time, except in the quiet stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // Hang detection: counts cycles in which neither stream moves a transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("[path_nearest_point_tracker] ERROR");
            $finish;
        end
    end

    function automatic int clamp24(int v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // One transfer on the slave stream. Called and returning just after a falling edge.
    task automatic send_item(logic op, int idx, int x, int y, int z);
        logic [23:0] bx;
        logic [23:0] by;
        logic [23:0] bz;
        while (!no_gaps && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        bx = x[23:0];
        by = y[23:0];
        bz = z[23:0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'd0, bz, by, bx, idx[9:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_LOAD) begin
            path_x[idx] = x;
            path_y[idx] = y;
            path_z[idx] = z;
            loaded[idx] = 1'b1;
            n_loads++;
        end else begin
            n_queries++;
        end
    endtask

    task automatic load_point(int idx, int x, int y, int z);
        send_item(OP_LOAD, idx, x, y, z);
    endtask

    task automatic query_at(int x, int y, int z);
        send_item(OP_QUERY, $urandom_range(1023), x, y, z);
    endtask

    // Registers change only once every expected result is out and the block has
    // had time to finish a trailing load.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[RANGE_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Loads every missing point below the effective length as a smooth walk with
    // steps of a few hundred millimetres, so that windows span a handful of points.
    task automatic fill_path(int len);
        int cx;
        int cy;
        int cz;
        cx = $urandom_range(16000000) - 8000000;
        cy = $urandom_range(16000000) - 8000000;
        cz = $urandom_range(16000000) - 8000000;
        for (int i = 0; i < len; i++) begin
            cx = clamp24(cx + int'($urandom_range(800)) - 400);
            cy = clamp24(cy + int'($urandom_range(800)) - 400);
            cz = clamp24(cz + int'($urandom_range(800)) - 400);
            if (!loaded[i]) load_point(i, cx, cy, cz);
        end
    endtask

    // One setting: mostly queries that follow the path with a drifting cursor,
    // some positions anywhere, some loads that rewrite points at any index.
    task automatic run_setting(int plen_value, int range_value, int count);
        int eff;
        int cursor;
        int pick;
        write_reg(CFG_PATH_LEN, plen_value);
        write_reg(CFG_RANGE, range_value);
        n_settings++;
        eff = plen_value < 2 ? 2 : (plen_value > MAX_POINTS ? MAX_POINTS : plen_value);
        fill_path(eff);
        cursor = $urandom_range(eff - 1);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                cursor = cursor + int'($urandom_range(8)) - 3;
                if (cursor < 0) cursor = 0;
                if (cursor > eff - 1) cursor = eff - 1;
                query_at(clamp24(path_x[cursor] + int'($urandom_range(600)) - 300),
                         clamp24(path_y[cursor] + int'($urandom_range(600)) - 300),
                         clamp24(path_z[cursor] + int'($urandom_range(600)) - 300));
            end else if (pick < 86) begin
                query_at(int'($urandom) >>> 8, int'($urandom) >>> 8, int'($urandom) >>> 8);
            end else begin
                load_point($urandom_range(1023),
                           int'($urandom) >>> 8, int'($urandom) >>> 8, int'($urandom) >>> 8);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = OP_LOAD;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PATH_LEN;
        i_cfg_data = '0;
        no_gaps = 1'b0;
        n_loads = 0;
        n_queries = 0;
        n_settings = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset settings: opposite corners of the coordinate
        // space make the end check and the distance as large as they can get.
        load_point(0, -8388608, -8388608, -8388608);
        load_point(1, 8388607, 8388607, 8388607);
        query_at(8388607, 8388607, 8388607);
        query_at(-8388608, -8388608, -8388608);
        query_at(0, 0, 0);
        query_at(-8388608, 8388607, -8388608);
        load_point(1023, 8388607, -8388608, 0);
        load_point(0, 0, 0, 0);
        load_point(1, 1000, 0, 0);
        query_at(1000, 0, 0);
        query_at(0, 0, 0);
        // Identical points give a zero-length path: tie goes to the first index.
        load_point(1, 0, 0, 0);
        query_at(5, -5, 5);

        // Zero range: the window collapses onto the previous point.
        run_setting(16, 0, 20);
        // Full range reaches both ends of a short path; also the quiet stretch.
        no_gaps = 1'b1;
        run_setting(16, 65535, 60);
        no_gaps = 1'b0;
        run_setting(40, 2000, 60);
        // Lengths below the minimum count as two points.
        run_setting(0, 1500, 30);
        run_setting(1, 300, 30);
        run_setting(64, 1200, 60);
        // Length beyond the store counts as the full store, which is filled here.
        run_setting(2047, 800, 40);
        run_setting(1024, 65535, 12);
        // Shrinking the path leaves the last found index past its end.
        run_setting(5, 3000, 40);
        run_setting(200, 2500, 270);
        run_setting(2, 65535, 30);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Covered %0d point loads and %0d position queries over %0d register settings,",
                 n_loads, n_queries, n_settings);
        $display("including empty windows, clamped path lengths and full-store paths.");
        if (fail_count == 0) begin
            $display("[path_nearest_point_tracker] OK");
        end else begin
            $display("%0d mismatches found", fail_count);
            $display("[path_nearest_point_tracker] ERROR");
        end
        $finish;
    end

endmodule
